@@ hdl/plc_pkg.sv @@
// Shared types and constants for the password lock controller.
// Used by plc_pass_buf and password_lock_controller_core; no dependencies.
`timescale 1ns / 1ps

package plc_pkg;

  localparam int unsigned PassLenDefault = 5;

  localparam int unsigned TickW  = 24;
  localparam int unsigned TriesW = 3;
  localparam int unsigned CfgW   = 24;
  localparam int unsigned MotorW = 2;

  localparam logic [TickW-1:0]  ROTATE_RESET = 24'd117187;  // 65535 + 51652
  localparam logic [TickW-1:0]  HOLD_RESET   = 24'd23437;
  localparam logic [TickW-1:0]  ALARM_RESET  = 24'd458745;  // 65535 * 7
  localparam logic [TriesW-1:0] TRIES_RESET  = 3'd3;

  localparam logic [7:0] BYTE_OPEN  = 8'h2B;  // '+'
  localparam logic [7:0] REPLY_NONE = 8'h00;
  localparam logic [7:0] REPLY_OK   = 8'h00;
  localparam logic [7:0] REPLY_BAD  = 8'h01;
  localparam logic [7:0] REPLY_WRONG = 8'h77;  // 'w'
  localparam logic [7:0] REPLY_READY = 8'h72;  // 'r'
  localparam logic [7:0] REPLY_ALARM = 8'h78;  // 'x'

  typedef enum logic [1:0] {
    MOTOR_STOP  = 2'd0,
    MOTOR_OPEN  = 2'd1,
    MOTOR_CLOSE = 2'd2
  } plc_motor_e;

  typedef enum logic {
    ITEM_BYTE = 1'b0,
    ITEM_TICK = 1'b1
  } plc_kind_e;

  typedef enum logic [1:0] {
    CFG_ROTATE = 2'd0,
    CFG_HOLD   = 2'd1,
    CFG_ALARM  = 2'd2,
    CFG_TRIES  = 2'd3
  } plc_cfg_e;

  typedef enum logic [7:0] {
    PH_ENTER   = 8'b0000_0001,
    PH_CONFIRM = 8'b0000_0010,
    PH_MENU    = 8'b0000_0100,
    PH_CHECK   = 8'b0000_1000,
    PH_OPEN    = 8'b0001_0000,
    PH_HOLD    = 8'b0010_0000,
    PH_CLOSE   = 8'b0100_0000,
    PH_ALARM   = 8'b1000_0000
  } plc_phase_e;

  // Control from the sequencer to the password buffers.
  typedef struct packed {
    logic wr_cand;  // write the byte into the candidate at the position
    logic commit;   // copy the candidate into the stored password
  } plc_buf_ctrl_t;

  // Compare results from the password buffers.
  typedef struct packed {
    logic cand_ne;    // candidate entry differs from the byte
    logic stored_ne;  // stored entry differs from the byte
  } plc_cmp_t;

endpackage

@@ hdl/plc_pass_buf.sv @@
// Candidate and stored password registers with per-position compare.
// Depends on plc_pkg.
`timescale 1ns / 1ps

module plc_pass_buf import plc_pkg::*; #(
  parameter int unsigned PASS_LEN = PassLenDefault
) (
  input  logic                                          clk_i,
  input  plc_buf_ctrl_t                                 ctrl_i,
  input  logic [((PASS_LEN > 1) ? $clog2(PASS_LEN) : 1)-1:0] pos_i,
  input  logic [7:0]                                    byte_i,
  output plc_cmp_t                                      cmp_o
);

  logic [7:0] cand_q   [PASS_LEN];
  logic [7:0] stored_q [PASS_LEN];

  // Entries hold nothing meaningful until written, so there is no reset.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_cand) begin
      cand_q[pos_i] <= byte_i;
    end
    if (ctrl_i.commit) begin
      stored_q <= cand_q;
    end
  end

  assign cmp_o.cand_ne   = (cand_q[pos_i] != byte_i);
  assign cmp_o.stored_ne = (stored_q[pos_i] != byte_i);

endmodule

@@ hdl/password_lock_controller_core.sv @@
// Password lock controller top level: input stage, sequencer and result register.
// Depends on plc_pkg and plc_pass_buf.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Words
// in        input      in_valid_i / in_ready_o    item_kind_i, rx_byte_i
// out       output     out_valid_o / out_ready_i  reply_valid_o, reply_byte_o,
//                                                 motor_drive_o, buzzer_drive_o,
//                                                 busy_res_o
// cfg       input      cfg_we_i (no wait)         cfg_idx_i, cfg_data_i
//
// Every input word yields exactly one output word. A word accepted into the
// input stage is processed into the result register as soon as that register
// can take it; with out_ready_i held high a new word is accepted every cycle.
// The input stage drains whenever the result register is empty or its word is
// taken in the same cycle; only a full input stage behind a result that is not
// taken stalls the input, and then in_ready_o drops.
// Reset puts the sequencer in password entry with the timing registers at
// their defaults; the password buffers hold nothing until written.

module password_lock_controller_core import plc_pkg::*; #(
  parameter int unsigned PASS_LEN = PassLenDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input words
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              item_kind_i,
  input  logic [7:0]        rx_byte_i,
  // Output words
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              reply_valid_o,
  output logic [7:0]        reply_byte_o,
  output logic [MotorW-1:0] motor_drive_o,
  output logic              buzzer_drive_o,
  output logic              busy_res_o,
  // Configuration writes
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [CfgW-1:0]   cfg_data_i
);

  localparam int unsigned PosW = (PASS_LEN > 1) ? $clog2(PASS_LEN) : 1;
  localparam logic [PosW-1:0] PosLast = PosW'(PASS_LEN - 1);

  // Configuration registers. User writes only while block is idle; unenforced.
  logic [TickW-1:0]  rotate_ticks_q, hold_ticks_q, alarm_ticks_q;
  logic [TriesW-1:0] max_tries_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotate_ticks_q <= ROTATE_RESET;
      hold_ticks_q   <= HOLD_RESET;
      alarm_ticks_q  <= ALARM_RESET;
      max_tries_q    <= TRIES_RESET;
    end else if (cfg_we_i) begin
      unique case (plc_cfg_e'(cfg_idx_i))
        CFG_ROTATE: rotate_ticks_q <= cfg_data_i[TickW-1:0];
        CFG_HOLD:   hold_ticks_q   <= cfg_data_i[TickW-1:0];
        CFG_ALARM:  alarm_ticks_q  <= cfg_data_i[TickW-1:0];
        CFG_TRIES:  max_tries_q    <= cfg_data_i[TriesW-1:0];
        default:    max_tries_q    <= max_tries_q;
      endcase
    end
  end

  // Input stage. The sequencer consumes it whenever the result register can
  // take a new word, so in_ready_o is high when the stage is empty or consumed.
  logic       stg_valid_q;
  plc_kind_e  stg_kind_q;
  logic [7:0] stg_byte_q;
  logic       advance;

  assign advance    = stg_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !stg_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      stg_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stg_kind_q <= plc_kind_e'(item_kind_i);
      stg_byte_q <= rx_byte_i;
    end
  end

  // Sequencer state.
  plc_phase_e        phase_q, phase_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic              match_q, match_d;
  logic [TriesW-1:0] attempt_q, attempt_d;
  logic [TickW-1:0]  tick_q, tick_d;

  plc_buf_ctrl_t buf_ctrl;
  plc_cmp_t      cmp;

  plc_pass_buf #(
    .PASS_LEN(PASS_LEN)
  ) u_pass_buf (
    .clk_i  (clk_i),
    .ctrl_i (buf_ctrl),
    .pos_i  (pos_q),
    .byte_i (stg_byte_q),
    .cmp_o  (cmp)
  );

  logic             is_last, is_tick;
  logic [TickW-1:0] tick_inc, tick_limit;
  logic             tick_hit;
  logic             rv_d;
  logic [7:0]       rb_d;

  assign is_last  = (pos_q == PosLast);
  assign is_tick  = (stg_kind_q == ITEM_TICK);
  assign tick_inc = tick_q + TickW'(1);

  // The hold phase has its own duration; every other timed phase is either a
  // motor turn or the alarm.
  always_comb begin
    priority if (phase_q == PH_HOLD) begin
      tick_limit = hold_ticks_q;
    end else if (phase_q == PH_ALARM) begin
      tick_limit = alarm_ticks_q;
    end else begin
      tick_limit = rotate_ticks_q;
    end
  end

  assign tick_hit = (tick_inc >= tick_limit);

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    match_d   = match_q;
    attempt_d = attempt_q;
    tick_d    = tick_q;
    rv_d      = 1'b0;
    rb_d      = REPLY_NONE;
    buf_ctrl  = '0;

    if (advance) begin
      unique case (phase_q)
        PH_ENTER: begin
          if (!is_tick) begin
            buf_ctrl.wr_cand = 1'b1;
            if (is_last) begin
              pos_d   = '0;
              match_d = 1'b1;
              phase_d = PH_CONFIRM;
            end else begin
              pos_d = pos_q + PosW'(1);
            end
          end
        end
        PH_CONFIRM: begin
          if (!is_tick) begin
            match_d = match_q && !cmp.cand_ne;
            if (is_last) begin
              pos_d = '0;
              rv_d  = 1'b1;
              if (match_q && !cmp.cand_ne) begin
                rb_d            = REPLY_OK;
                buf_ctrl.commit = 1'b1;
                phase_d         = PH_MENU;
              end else begin
                // Confirmation failed: set-up starts over.
                rb_d      = REPLY_BAD;
                phase_d   = PH_ENTER;
                match_d   = 1'b1;
                attempt_d = '0;
              end
            end else begin
              pos_d = pos_q + PosW'(1);
            end
          end
        end
        PH_MENU: begin
          if (!is_tick) begin
            pos_d   = '0;
            match_d = 1'b1;
            if (stg_byte_q == BYTE_OPEN) begin
              attempt_d = TriesW'(1);
              phase_d   = PH_CHECK;
            end else begin
              attempt_d = '0;
              phase_d   = PH_ENTER;
            end
          end
        end
        PH_CHECK: begin
          if (!is_tick) begin
            match_d = match_q && !cmp.stored_ne;
            if (is_last) begin
              pos_d = '0;
              if (match_q && !cmp.stored_ne) begin
                tick_d  = '0;
                phase_d = PH_OPEN;
              end else if (attempt_q >= max_tries_q) begin
                // A max_tries of zero also lands here on the first attempt.
                rv_d    = 1'b1;
                rb_d    = REPLY_ALARM;
                tick_d  = '0;
                phase_d = PH_ALARM;
              end else begin
                rv_d      = 1'b1;
                rb_d      = REPLY_WRONG;
                attempt_d = attempt_q + TriesW'(1);
                match_d   = 1'b1;
              end
            end else begin
              pos_d = pos_q + PosW'(1);
            end
          end
        end
        PH_OPEN, PH_HOLD, PH_CLOSE, PH_ALARM: begin
          // Bytes are ignored while busy; ticks advance the timer.
          if (is_tick) begin
            tick_d = tick_hit ? '0 : tick_inc;
            if (tick_hit) begin
              unique case (phase_q)
                PH_OPEN:  phase_d = PH_HOLD;
                PH_HOLD:  phase_d = PH_CLOSE;
                PH_CLOSE: begin
                  rv_d    = 1'b1;
                  rb_d    = REPLY_READY;
                  phase_d = PH_MENU;
                end
                default:  phase_d = PH_MENU;
              endcase
            end
          end
        end
        default: phase_d = PH_ENTER;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_ENTER;
      pos_q     <= '0;
      match_q   <= 1'b1;
      attempt_q <= '0;
      tick_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      match_q   <= match_d;
      attempt_q <= attempt_d;
      tick_q    <= tick_d;
    end
  end

  // Result register. The drive outputs reflect the phase after the word.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      reply_valid_o  <= rv_d;
      reply_byte_o   <= rb_d;
      motor_drive_o  <= (phase_d == PH_OPEN)  ? MOTOR_OPEN  :
                        (phase_d == PH_CLOSE) ? MOTOR_CLOSE : MOTOR_STOP;
      buzzer_drive_o <= (phase_d == PH_ALARM);
      busy_res_o     <= (phase_d == PH_OPEN) || (phase_d == PH_HOLD) ||
                        (phase_d == PH_CLOSE) || (phase_d == PH_ALARM);
    end
  end

  assign out_valid_o = out_valid_q;

  // Checks on the sequencer and the stage coupling.
  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("sequencer phase is not one-hot");

  a_check_attempt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_CHECK) |-> (attempt_q != '0))
    else $error("password check running with no attempt counted");

  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (motor_drive_o != MOTOR_STOP || buzzer_drive_o) |-> busy_res_o)
    else $error("motor or buzzer driven while not busy");

  a_no_reply_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !reply_valid_o |-> (reply_byte_o == REPLY_NONE))
    else $error("reply code present without a reply");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (stg_valid_q && out_valid_o && !out_ready_i))
    else $error("input stalled while the result register can move");

endmodule

@@ dv/password_lock_controller_core_test.sv @@
// Testbench for password_lock_controller_core: directed and random keypad traffic
// checked word by word against an in-bench model of the lock sequencer.
// Depends on plc_pkg and the controller RTL; needs no other files.
`timescale 1ns / 1ps

module password_lock_controller_core_test;
  import plc_pkg::*;

  localparam int unsigned PW         = PassLenDefault;
  localparam int          StallLimit = 5000;

  // One output word as the block presents it.
  typedef struct packed {
    logic       reply_valid;
    logic [7:0] reply_byte;
    plc_motor_e motor;
    logic       buzzer;
    logic       busy;
  } lock_out_t;

  // Every input starts at a known value; reset is held from time zero.
  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic              item_kind_i  = 1'b0;
  logic [7:0]        rx_byte_i    = 8'h00;
  logic              out_ready_i  = 1'b0;
  logic              cfg_we_i     = 1'b0;
  logic [1:0]        cfg_idx_i    = 2'd0;
  logic [CfgW-1:0]   cfg_data_i   = '0;
  logic              in_ready_o;
  logic              out_valid_o;
  logic              reply_valid_o;
  logic [7:0]        reply_byte_o;
  logic [MotorW-1:0] motor_drive_o;
  logic              buzzer_drive_o;
  logic              busy_res_o;

  password_lock_controller_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .item_kind_i    (item_kind_i),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .reply_valid_o  (reply_valid_o),
    .reply_byte_o   (reply_byte_o),
    .motor_drive_o  (motor_drive_o),
    .buzzer_drive_o (buzzer_drive_o),
    .busy_res_o     (busy_res_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Lock model. It mirrors the sequencer state and the four configuration registers
  // and is advanced once for every word the block accepts.
  // ---------------------------------------------------------------------------
  plc_phase_e        lock_phase = PH_ENTER;
  int                byte_pos   = 0;
  logic [7:0]        cand_bytes [PW];
  logic [7:0]        stored_pw  [PW];
  bit                all_same   = 1'b1;
  logic [TriesW-1:0] tries_used = '0;
  logic [TickW-1:0]  tick_cnt   = '0;

  logic [TickW-1:0]  rot_limit   = ROTATE_RESET;
  logic [TickW-1:0]  hold_limit  = HOLD_RESET;
  logic [TickW-1:0]  alarm_limit = ALARM_RESET;
  logic [TriesW-1:0] tries_limit = TRIES_RESET;

  // Replies predicted for accepted words, oldest first.
  lock_out_t pending_replies [$];
  int        mismatch_count = 0;

  // While set, neither side inserts idle cycles.
  bit steady_flow = 1'b0;

  // Random attempt plan for the current password check.
  bit attempt_ok = 1'b1;
  int bad_slot   = 0;

  function automatic bit is_busy();
    return lock_phase inside {PH_OPEN, PH_HOLD, PH_CLOSE, PH_ALARM};
  endfunction

  function automatic void restart_entry();
    lock_phase = PH_ENTER;
    byte_pos   = 0;
    all_same   = 1'b1;
    tries_used = '0;
  endfunction

  // One tick against a duration; a zero duration expires on the first tick.
  function automatic bit timer_expired(logic [TickW-1:0] limit);
    tick_cnt = tick_cnt + TickW'(1);
    if (tick_cnt >= limit) begin
      tick_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic lock_out_t advance_lock(plc_kind_e kind, logic [7:0] val);
    lock_out_t w;
    bit        at_end;
    w      = '0;
    at_end = (byte_pos + 1 >= PW);
    if (kind == ITEM_BYTE) begin
      case (lock_phase)
        PH_ENTER: begin
          cand_bytes[byte_pos] = val;
          if (at_end) begin
            byte_pos   = 0;
            all_same   = 1'b1;
            lock_phase = PH_CONFIRM;
          end else begin
            byte_pos++;
          end
        end
        PH_CONFIRM: begin
          if (cand_bytes[byte_pos] != val) all_same = 1'b0;
          if (at_end) begin
            byte_pos      = 0;
            w.reply_valid = 1'b1;
            if (all_same) begin
              w.reply_byte = REPLY_OK;
              stored_pw    = cand_bytes;
              lock_phase   = PH_MENU;
            end else begin
              w.reply_byte = REPLY_BAD;
              restart_entry();
            end
          end else begin
            byte_pos++;
          end
        end
        PH_MENU: begin
          if (val == BYTE_OPEN) begin
            tries_used = 3'd1;
            all_same   = 1'b1;
            byte_pos   = 0;
            lock_phase = PH_CHECK;
          end else begin
            restart_entry();
          end
        end
        PH_CHECK: begin
          if (stored_pw[byte_pos] != val) all_same = 1'b0;
          if (at_end) begin
            byte_pos = 0;
            if (all_same) begin
              tick_cnt   = '0;
              lock_phase = PH_OPEN;
            end else if (tries_used >= tries_limit) begin
              // A try limit of zero behaves like a single attempt.
              w.reply_valid = 1'b1;
              w.reply_byte  = REPLY_ALARM;
              tick_cnt      = '0;
              lock_phase    = PH_ALARM;
            end else begin
              w.reply_valid = 1'b1;
              w.reply_byte  = REPLY_WRONG;
              tries_used    = tries_used + TriesW'(1);
              all_same      = 1'b1;
            end
          end else begin
            byte_pos++;
          end
        end
        default: begin
          // Bytes that arrive during the door sequence or the alarm are dropped.
        end
      endcase
    end else begin
      case (lock_phase)
        PH_OPEN: begin
          if (timer_expired(rot_limit)) lock_phase = PH_HOLD;
        end
        PH_HOLD: begin
          if (timer_expired(hold_limit)) lock_phase = PH_CLOSE;
        end
        PH_CLOSE: begin
          if (timer_expired(rot_limit)) begin
            w.reply_valid = 1'b1;
            w.reply_byte  = REPLY_READY;
            lock_phase    = PH_MENU;
          end
        end
        PH_ALARM: begin
          if (timer_expired(alarm_limit)) lock_phase = PH_MENU;
        end
        default: begin
          // Ticks outside a timed phase have no effect.
        end
      endcase
    end
    w.motor  = (lock_phase == PH_OPEN)  ? MOTOR_OPEN  :
               (lock_phase == PH_CLOSE) ? MOTOR_CLOSE : MOTOR_STOP;
    w.buzzer = (lock_phase == PH_ALARM);
    w.busy   = is_busy();
    return w;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (steady_flow || r < 50) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Inputs change on the falling edge; handshakes are sampled on the
  // rising edge.
  // ---------------------------------------------------------------------------

  // Presents one word, holds it until accepted and records the predicted reply.
  task automatic send_word(input plc_kind_e kind, input logic [7:0] val);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    item_kind_i <= kind;
    rx_byte_i   <= val;
    do @(posedge clk_i); while (!in_ready_o);
    pending_replies.push_back(advance_lock(kind, val));
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_word(ITEM_TICK, 8'h00);
  endtask

  // Sends the stored password with every byte xored by flip.
  task automatic send_code(input logic [7:0] flip);
    for (int i = 0; i < PW; i++) send_word(ITEM_BYTE, stored_pw[i] ^ flip);
  endtask

  // Stops input and waits until every predicted reply has been checked.
  task automatic settle_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input plc_cfg_e idx, input logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_ROTATE: rot_limit   = val;
      CFG_HOLD:   hold_limit  = val;
      CFG_ALARM:  alarm_limit = val;
      CFG_TRIES:  tries_limit = val[TriesW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Chooses the next word from the current lock phase so that most traffic is
  // well-formed: confirmations mostly repeat the candidate, menu bytes are
  // mostly open requests, and timed phases mostly receive ticks.
  task automatic pick_word(output plc_kind_e kind, output logic [7:0] val);
    int r;
    r    = $urandom_range(99, 0);
    kind = ITEM_BYTE;
    val  = 8'($urandom_range(255, 0));
    case (lock_phase)
      PH_ENTER: begin
        if (r < 3) kind = ITEM_TICK;
      end
      PH_CONFIRM: begin
        if (r < 3) kind = ITEM_TICK;
        else if (r >= 7) val = cand_bytes[byte_pos];
      end
      PH_MENU: begin
        if (r < 3) kind = ITEM_TICK;
        else if (r < 88) val = BYTE_OPEN;
      end
      PH_CHECK: begin
        if (byte_pos == 0) begin
          attempt_ok = ($urandom_range(99, 0) < 60);
          bad_slot   = $urandom_range(PW - 1, 0);
        end
        if (r < 3) kind = ITEM_TICK;
        else if (attempt_ok || byte_pos != bad_slot) val = stored_pw[byte_pos];
        else val = stored_pw[byte_pos] ^ 8'($urandom_range(255, 1));
      end
      default: begin
        if (r < 90) kind = ITEM_TICK;
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Password set-up with extreme byte values, a wrong and a right check, a byte
  // and a tick while busy, a tick while idle, and a zero rotate duration.
  task automatic test_directed_session();
    logic [7:0] code [PW];
    code = '{8'h00, 8'hFF, 8'h55, 8'hAA, BYTE_OPEN};
    send_word(ITEM_TICK, 8'h00);
    for (int i = 0; i < PW; i++) send_word(ITEM_BYTE, code[i]);
    for (int i = 0; i < PW; i++) send_word(ITEM_BYTE, code[i]);
    send_word(ITEM_BYTE, BYTE_OPEN);
    send_code(8'h80);
    send_code(8'h00);
    send_word(ITEM_BYTE, BYTE_OPEN);
    send_ticks(1);
    // The door is opening on the long reset duration; cut it short.
    settle_block();
    write_reg(CFG_ROTATE, '0);
    write_reg(CFG_HOLD, 24'd1);
    send_ticks(3);
  endtask

  // Largest durations and a try limit of zero. The alarm, open and hold phases are
  // each entered on the full-scale value and then released by writing a short one.
  task automatic test_timer_extremes();
    settle_block();
    write_reg(CFG_ROTATE, '1);
    write_reg(CFG_HOLD, '1);
    write_reg(CFG_ALARM, '1);
    write_reg(CFG_TRIES, '0);
    send_word(ITEM_BYTE, BYTE_OPEN);
    send_code(8'h01);
    send_ticks(12);
    send_word(ITEM_BYTE, 8'h00);
    settle_block();
    write_reg(CFG_ALARM, 24'd1);
    send_ticks(1);
    send_word(ITEM_BYTE, BYTE_OPEN);
    send_code(8'h00);
    send_ticks(12);
    settle_block();
    write_reg(CFG_ROTATE, 24'd2);
    send_ticks(5);
    settle_block();
    write_reg(CFG_HOLD, '0);
    send_ticks(3);
  endtask

  // One random round under a fresh register setting. Only words that the block
  // acts on count toward the total.
  task automatic test_random_round(input int words, input int lo_dur, input int hi_dur,
                                   input int lo_tries, input int hi_tries,
                                   input bit no_gaps);
    plc_kind_e  kind;
    logic [7:0] val;
    int         acted;
    settle_block();
    write_reg(CFG_ROTATE, CfgW'($urandom_range(hi_dur, lo_dur)));
    write_reg(CFG_HOLD, CfgW'($urandom_range(hi_dur, lo_dur)));
    write_reg(CFG_ALARM, CfgW'($urandom_range(hi_dur, lo_dur)));
    write_reg(CFG_TRIES, CfgW'($urandom_range(hi_tries, lo_tries)));
    steady_flow = no_gaps;
    acted       = 0;
    while (acted < words) begin
      pick_word(kind, val);
      if ((kind == ITEM_TICK) == is_busy()) acted++;
      send_word(kind, val);
    end
    steady_flow = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure and the reply check.
  // ---------------------------------------------------------------------------
  initial begin : sink_pacing
    int stall;
    int run;
    forever begin
      stall = pick_gap();
      run   = $urandom_range(8, 1);
      if (stall > 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      repeat (run - 1) @(negedge clk_i);
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : reply_monitor
    lock_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_replies.size() == 0) begin
        $display("%0t ns: word with nothing expected, got reply %0b/%0h motor %0d",
                 $time, reply_valid_o, reply_byte_o, motor_drive_o);
        mismatch_count++;
      end else begin
        want = pending_replies.pop_front();
        check_field("reply_valid", 8'(want.reply_valid), 8'(reply_valid_o));
        check_field("reply_byte", want.reply_byte, reply_byte_o);
        check_field("motor_drive", 8'(want.motor), 8'(motor_drive_o));
        check_field("buzzer_drive", 8'(want.buzzer), 8'(buzzer_drive_o));
        check_field("busy_res", 8'(want.busy), 8'(busy_res_o));
      end
    end
  end

  // Ends the run if neither channel moves a word for too long.
  initial begin : stall_watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : main_sequence
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_session();
    test_timer_extremes();
    // Short timers across try limits from one to seven.
    test_random_round(220, 1, 6, 1, 7, 1'b0);
    // Back-to-back traffic, one-tick timers, most tries.
    test_random_round(120, 1, 1, 7, 7, 1'b1);
    // Zero durations and a single try.
    test_random_round(120, 0, 0, 1, 1, 1'b0);
    // Wider durations and try limits including zero.
    test_random_round(220, 0, 25, 0, 7, 1'b0);
    settle_block();
    repeat (4) @(posedge clk_i);
    if (pending_replies.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
